### rtl/core/pca_pkg.sv
// package: constants, codes and controller/datapath command and status types
package pca_pkg;

    localparam int SIDE      = 64;
    localparam int CELL_IDS  = 16;
    localparam int XB        = $clog2(SIDE);
    localparam int LAT_AW    = 2 * XB;
    localparam int LAT_DEPTH = SIDE * SIDE;
    localparam int ID_W      = 4;
    localparam int VOL_W     = 13;
    localparam int DH_W      = 26;
    localparam int ROM_AW    = 12;
    localparam int ROM_DEPTH = 1 << ROM_AW;
    localparam int INIT_N    = (LAT_DEPTH > ROM_DEPTH) ? LAT_DEPTH : ROM_DEPTH;
    localparam int INIT_AW   = $clog2(INIT_N);
    localparam int DIV_CW    = $clog2(ROM_AW);
    localparam int CFG_IW    = 8;
    localparam int CFG_DW    = 16;

    localparam logic [31:0] EXP_STEP = 32'd4278222805;
    localparam logic [VOL_W-1:0] VOL_RESET0 = VOL_W'(LAT_DEPTH);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_COPY = 1'b1;

    localparam logic [CFG_IW-1:0] CFG_ADHESION    = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_TARGET_VOL  = 8'd1;
    localparam logic [CFG_IW-1:0] CFG_VOL_WEIGHT  = 8'd2;
    localparam logic [CFG_IW-1:0] CFG_TEMPERATURE = 8'd3;

    typedef enum logic [2:0] {
        TAG_SITE,
        TAG_NB0,
        TAG_NB1,
        TAG_NB2,
        TAG_NB3
    } rd_tag_t;

    typedef struct packed {
        logic       req_type;
        logic [5:0] site_x;
        logic [5:0] site_y;
        logic [3:0] cell_id;
        logic [1:0] direction;
        logic [15:0] uniform_draw;
    } pca_req_t;

    typedef struct packed {
        logic    init_step;
        logic    latch;
        logic    rd_en;
        rd_tag_t rd_tag;
        logic    sel_nid;
        logic    vol_rd_old;
        logic    vol_rd_new;
        logic    mul;
        logic    sum;
        logic    acc_set;
        logic    div_start;
        logic    div_step;
        logic    rom_rd;
        logic    cmp;
        logic    commit;
    } pca_cmd_t;

    typedef struct packed {
        logic init_done;
        logic is_load;
        logic dh_le0;
        logic reject_fast;
        logic div_last;
        logic out_free;
    } pca_status_t;

endpackage

### rtl/core/pca_if.sv
// channel interfaces: request, response and configuration write
interface pca_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [5:0]  site_x;
    logic [5:0]  site_y;
    logic [3:0]  cell_id;
    logic [1:0]  direction;
    logic [15:0] uniform_draw;
    modport source (output valid, req_type, site_x, site_y, cell_id, direction,
                    uniform_draw, input ready);
    modport sink (input valid, req_type, site_x, site_y, cell_id, direction,
                  uniform_draw, output ready);
endinterface

interface pca_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [25:0] delta_energy;
    logic [3:0]  old_cell;
    modport source (output valid, accepted, delta_energy, old_cell, input ready);
    modport sink (input valid, accepted, delta_energy, old_cell, output ready);
endinterface

interface pca_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/potts_copy_attempt.sv
// top level: cellular potts copy attempt block
//  channel | dir | accepted when
//  req     | in  | req.valid && req.ready
//  rsp     | out | rsp.valid && rsp.ready
//  cfg     | in  | cfg.valid && cfg.ready (always ready)
// a load request is shorter than a copy request, which is longer still when the
// probability path runs (12-step serial divide by temperature, then the exp table)
// after reset a clearing pass clears the lattice and builds the exp table;
// no request is taken meanwhile
// a finished response sits in an output register; a stalled response holds the
// next request at its final step only
module potts_copy_attempt (
    input logic       clk,
    input logic       rst_n,
    pca_req_if.sink   req,
    pca_rsp_if.source rsp,
    pca_cfg_if.sink   cfg
);
    import pca_pkg::*;

    pca_cmd_t    cmd;
    pca_status_t st;
    pca_req_t    req_fields;

    assign req_fields.req_type     = req.req_type;
    assign req_fields.site_x       = req.site_x;
    assign req_fields.site_y       = req.site_y;
    assign req_fields.cell_id      = req.cell_id;
    assign req_fields.direction    = req.direction;
    assign req_fields.uniform_draw = req.uniform_draw;

    assign cfg.ready = 1'b1;

    pca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    pca_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .req              (req_fields),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_accepted     (rsp.accepted),
        .rsp_delta_energy (rsp.delta_energy),
        .rsp_old_cell     (rsp.old_cell)
    );

endmodule

### rtl/core/pca_ctrl.sv
// controller: sequences loads, copy attempts and the power-up clearing pass
module pca_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  pca_pkg::pca_status_t st,
    output pca_pkg::pca_cmd_t    cmd
);
    import pca_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_LD_RD,
        S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
        S_SEL, S_VO, S_VN, S_MUL, S_SUM, S_DEC,
        S_DIV, S_ROM, S_CMP, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_tag = TAG_SITE;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (st.init_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.latch = accept;
                if (accept)
                    state_next = S_LD_RD;
            end
            S_LD_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_tag = TAG_SITE;
                state_next = st.is_load ? S_FIN : S_RD1;
            end
            S_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_tag = TAG_NB0;
                state_next = S_RD2;
            end
            S_RD1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_tag = TAG_NB0;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_tag = TAG_NB1;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_tag = TAG_NB2;
                state_next = S_RD4;
            end
            S_RD4:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_tag = TAG_NB3;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                cmd.sel_nid = 1'b1;
                state_next  = S_VO;
            end
            S_VO:
            begin
                cmd.vol_rd_old = 1'b1;
                state_next     = S_VN;
            end
            S_VN:
            begin
                cmd.vol_rd_new = 1'b1;
                state_next     = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                priority if (st.dh_le0)
                begin
                    cmd.acc_set = 1'b1;
                    state_next  = S_FIN;
                end
                else if (st.reject_fast)
                    state_next = S_FIN;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                    state_next = S_ROM;
            end
            S_ROM:
            begin
                cmd.rom_rd = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.commit = st.out_free;
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/pca_datapath.sv
// datapath: lattice memory, exp table, volumes, energy arithmetic and divider
module pca_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pca_pkg::pca_cmd_t             cmd,
    output pca_pkg::pca_status_t          st,
    input  pca_pkg::pca_req_t             req,
    input  logic                          cfg_we,
    input  logic [pca_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [pca_pkg::CFG_DW-1:0]    cfg_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          rsp_accepted,
    output logic [pca_pkg::DH_W-1:0]      rsp_delta_energy,
    output logic [pca_pkg::ID_W-1:0]      rsp_old_cell
);
    import pca_pkg::*;

    // configuration
    logic [9:0]       adh_j_reg;
    logic [VOL_W-1:0] v0_reg;
    logic [9:0]       lambda_reg;
    logic [15:0]      temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adh_j_reg  <= 10'd100;
            v0_reg     <= 13'd100;
            lambda_reg <= 10'd50;
            temp_reg   <= 16'd2560;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ADHESION:    adh_j_reg  <= cfg_data[9:0];
                CFG_TARGET_VOL:  v0_reg     <= cfg_data[VOL_W-1:0];
                CFG_VOL_WEIGHT:  lambda_reg <= cfg_data[9:0];
                CFG_TEMPERATURE: temp_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // latched request
    logic [XB-1:0]   x_reg, y_reg;
    logic [ID_W-1:0] id_reg;
    logic [1:0]      dir_reg;
    logic [15:0]     draw_reg;
    logic            is_load_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            x_reg       <= XB'(req.site_x % SIDE);
            y_reg       <= XB'(req.site_y % SIDE);
            id_reg      <= req.cell_id;
            dir_reg     <= req.direction;
            draw_reg    <= req.uniform_draw;
            is_load_reg <= (req.req_type == REQ_LOAD);
        end
    end

    logic [LAT_AW-1:0] site_addr, rd_addr;
    logic [LAT_AW-1:0] nb_addr [4];

    assign site_addr  = {y_reg, x_reg};
    assign nb_addr[0] = {y_reg, XB'(x_reg + 1'b1)};
    assign nb_addr[1] = {y_reg, XB'(x_reg - 1'b1)};
    assign nb_addr[2] = {XB'(y_reg + 1'b1), x_reg};
    assign nb_addr[3] = {XB'(y_reg - 1'b1), x_reg};

    always_comb
    begin
        unique case (cmd.rd_tag)
            TAG_NB0: rd_addr = nb_addr[0];
            TAG_NB1: rd_addr = nb_addr[1];
            TAG_NB2: rd_addr = nb_addr[2];
            TAG_NB3: rd_addr = nb_addr[3];
            default: rd_addr = site_addr;
        endcase
    end

    // init sweep: clears the lattice and builds the exp table
    logic [INIT_AW:0] init_k_reg;
    logic             phase_reg;
    logic [32:0]      v_reg;
    logic [47:0]      plo_reg;
    logic [48:0]      phi;
    logic [65:0]      vsum;
    logic [33:0]      vround;
    logic [15:0]      rom_wdata;
    logic             init_a, init_b;

    assign init_a = cmd.init_step && !phase_reg;
    assign init_b = cmd.init_step && phase_reg;
    assign phi    = v_reg[32:16] * EXP_STEP;
    assign vsum   = {1'b0, phi, 16'b0} + {18'b0, plo_reg} + 66'h0_8000_0000;
    assign vround = {1'b0, v_reg} + 34'h8000;
    assign rom_wdata = (vround[32:16] > 17'd65535) ? 16'hFFFF : vround[31:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_k_reg <= '0;
            phase_reg  <= 1'b0;
            v_reg      <= 33'h1_0000_0000;
        end
        else if (cmd.init_step && !init_k_reg[INIT_AW])
        begin
            phase_reg <= !phase_reg;
            if (phase_reg)
            begin
                v_reg      <= vsum[64:32];
                init_k_reg <= init_k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (init_a)
            plo_reg <= v_reg[15:0] * EXP_STEP;
    end

    // lattice memory
    logic [ID_W-1:0] lattice_mem [LAT_DEPTH];
    logic [ID_W-1:0] old_reg, nid_reg;
    logic [ID_W-1:0] nb_reg [4];
    logic            acc_reg;
    logic            wr_ok;
    logic [ID_W-1:0] wid;

    assign wr_ok = is_load_reg ? (int'(id_reg) < CELL_IDS) : acc_reg;
    assign wid   = is_load_reg ? id_reg : nid_reg;

    always_ff @(posedge clk)
    begin
        if (init_a && !init_k_reg[INIT_AW] && (int'(init_k_reg) < LAT_DEPTH))
            lattice_mem[init_k_reg[LAT_AW-1:0]] <= '0;
        else if (cmd.commit && wr_ok)
            lattice_mem[site_addr] <= wid;
        if (cmd.rd_en)
        begin
            unique case (cmd.rd_tag)
                TAG_NB0: nb_reg[0] <= lattice_mem[rd_addr];
                TAG_NB1: nb_reg[1] <= lattice_mem[rd_addr];
                TAG_NB2: nb_reg[2] <= lattice_mem[rd_addr];
                TAG_NB3: nb_reg[3] <= lattice_mem[rd_addr];
                default: old_reg   <= lattice_mem[rd_addr];
            endcase
        end
        if (cmd.sel_nid)
            nid_reg <= nb_reg[dir_reg];
    end

    // exp table
    logic [15:0]       exp_rom [ROM_DEPTH];
    logic [15:0]       rom_q_reg;
    logic [ROM_AW-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (init_b && !init_k_reg[INIT_AW] && (int'(init_k_reg) < ROM_DEPTH))
            exp_rom[init_k_reg[ROM_AW-1:0]] <= rom_wdata;
        if (cmd.rom_rd)
            rom_q_reg <= exp_rom[q_reg];
    end

    // volumes
    logic [VOL_W-1:0] vol_reg [CELL_IDS];
    logic [VOL_W-1:0] vo_reg, vn_reg, vol_rdata;
    logic [ID_W-1:0]  vol_sel;

    assign vol_sel   = cmd.vol_rd_new ? nid_reg : old_reg;
    assign vol_rdata = vol_reg[vol_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_IDS; i++)
                vol_reg[i] <= (i == 0) ? VOL_RESET0 : '0;
        end
        else if (cmd.commit && wr_ok)
        begin
            for (int i = 0; i < CELL_IDS; i++)
                vol_reg[i] <= VOL_W'(vol_reg[i] + VOL_W'(ID_W'(i) == wid)
                                    - VOL_W'(ID_W'(i) == old_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vol_rd_old)
            vo_reg <= vol_rdata;
        if (cmd.vol_rd_new)
            vn_reg <= vol_rdata;
    end

    // energy change
    logic signed [3:0]  cdiff;
    logic signed [14:0] adh_prod, adh_reg;
    logic signed [14:0] bo, bn;
    logic signed [15:0] dvol;
    logic signed [26:0] vt_prod, vt_reg, dh_sum;
    logic signed [DH_W-1:0] dh_reg;

    always_comb
    begin
        cdiff = '0;
        for (int k = 0; k < 4; k++)
            cdiff = cdiff + $signed({3'b0, nid_reg != nb_reg[k]})
                          - $signed({3'b0, old_reg != nb_reg[k]});
    end

    assign adh_prod = $signed({1'b0, adh_j_reg}) * cdiff;
    assign bo       = $signed({2'b0, vo_reg}) - $signed({2'b0, v0_reg});
    assign bn       = $signed({2'b0, vn_reg}) - $signed({2'b0, v0_reg});
    assign dvol     = 16'sd1 + 16'(bn) - 16'(bo);
    assign vt_prod  = $signed({1'b0, lambda_reg, 1'b0}) * dvol;
    assign dh_sum   = 27'(adh_reg) + vt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            adh_reg <= adh_prod;
            vt_reg  <= vt_prod;
        end
        if (cmd.sum)
            dh_reg <= (nid_reg == old_reg) ? '0 : dh_sum[DH_W-1:0];
    end

    // acceptance and divider
    logic [15:0]       rem_reg;
    logic [16:0]       rem_dbl;
    logic              rem_ge;
    logic [DIV_CW-1:0] div_cnt_reg;
    logic [28:0]       dh_x16;

    assign dh_x16  = {dh_reg[24:0], 4'b0};
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = rem_dbl >= {1'b0, temp_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= 1'b0;
        else if (cmd.latch)
            acc_reg <= 1'b0;
        else if (cmd.acc_set || (cmd.cmp && (draw_reg < rom_q_reg)))
            acc_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg     <= {dh_reg[11:0], 4'b0};
            q_reg       <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_ge ? 16'(rem_dbl - {1'b0, temp_reg}) : rem_dbl[15:0];
            q_reg       <= {q_reg[ROM_AW-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // response register
    logic                   out_valid_reg, out_acc_reg;
    logic [DH_W-1:0]        out_dh_reg;
    logic [ID_W-1:0]        out_old_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= cmd.commit || (out_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_acc_reg <= acc_reg;
            out_dh_reg  <= is_load_reg ? '0 : dh_reg;
            out_old_reg <= old_reg;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_accepted     = out_acc_reg;
    assign rsp_delta_energy = out_dh_reg;
    assign rsp_old_cell     = out_old_reg;

    assign st.init_done   = init_k_reg[INIT_AW];
    assign st.is_load     = is_load_reg;
    assign st.dh_le0      = dh_reg[DH_W-1] || (dh_reg == '0);
    assign st.reject_fast = (temp_reg == '0) || (dh_x16 >= {13'b0, temp_reg});
    assign st.div_last    = (div_cnt_reg == DIV_CW'(ROM_AW - 1));
    assign st.out_free    = !out_valid_reg || rsp_ready;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || rsp_ready))
        else $error("commit while response register busy");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("response not presented after commit");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_load_reg) |=> (!out_acc_reg && (out_dh_reg == '0)))
        else $error("load reported a copy result");

    a_no_step_init: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.latch || cmd.commit) |-> init_k_reg[INIT_AW])
        else $error("request handled before clearing pass ended");

endmodule
